### src/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // One input item: an 8-bit RGB pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One result item: 8-bit hue, saturation and brightness.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // The channel that holds the largest value selects the hue sector.
    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    localparam logic [7:0] HUE_OFS_RED   = 8'd0;
    localparam logic [7:0] HUE_OFS_GREEN = 8'd85;
    localparam logic [7:0] HUE_OFS_BLUE  = 8'd171;
    localparam logic [5:0] HUE_SCALE     = 6'd43;

    // Reciprocal width: ceil(2^RECIP_SHIFT / d) gives an exact floor quotient
    // for any numerator below 2^16 and any divisor from 1 to 255.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

endpackage

### src/rgb_to_hsv_pixel_converter_core.sv
// RGB to HSV pixel converter: four register stages (A, B, C and the result
// register) from the accepting edge of start to the done strobe.
// Throughput is one item per clock; busy is held low since nothing stalls.
// Reset (rst_n, asynchronous, active low) clears all valid bits and done;
// payload registers are not reset. The receiver cannot stall the pipeline.
module rgb_to_hsv_pixel_converter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsv_pkg::pixel_t  pixel,
    output logic                done,
    output rgbhsv_pkg::hsv_t    result
);

    localparam int RW = rgbhsv_pkg::RECIP_W;
    localparam int RS = rgbhsv_pkg::RECIP_SHIFT;

    // Reciprocal table, worked out at elaboration: entry d holds
    // ceil(2^RS / d). Entry 0 is never used for a real division, since a
    // zero spread (which any zero largest channel also gives) takes the grey path.
    logic [RW-1:0] recip_lut [256];

    for (genvar d = 0; d < 256; d++) begin : g_recip
        localparam int DIV = (d == 0) ? 1 : d;
        localparam logic [RW-1:0] RC =
            (d == 0) ? '0 : RW'(((64'd1 << RS) + DIV - 1) / DIV);
        assign recip_lut[d] = RC;
    end

    // The converter never holds off an input item.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: largest and smallest channel, sector, signed difference.
    // ------------------------------------------------------------------
    logic                  a_valid_reg;
    logic [7:0]            a_hi_reg,     a_hi_next;
    logic [7:0]            a_spread_reg, a_spread_next;
    rgbhsv_pkg::sector_t   a_sector_reg, a_sector_next;
    logic signed [8:0]     a_diff_reg,   a_diff_next;

    always_comb
    begin
        logic [7:0] lo;
        logic       r_ge_g, r_ge_b, g_ge_b;
        r_ge_g = pixel.red >= pixel.green;
        r_ge_b = pixel.red >= pixel.blue;
        g_ge_b = pixel.green >= pixel.blue;

        // Ties go to red first, then green.
        if (r_ge_g && r_ge_b)
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_RED;
            a_hi_next     = pixel.red;
            a_diff_next   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
        end
        else if (g_ge_b)
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_GREEN;
            a_hi_next     = pixel.green;
            a_diff_next   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
        end
        else
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_BLUE;
            a_hi_next     = pixel.blue;
            a_diff_next   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
        end

        lo = pixel.red;
        if (pixel.green < lo)
        begin
            lo = pixel.green;
        end
        if (pixel.blue < lo)
        begin
            lo = pixel.blue;
        end
        a_spread_next = a_hi_next - lo;
    end

    // ------------------------------------------------------------------
    // Stage B: reciprocal lookups and the two dividends.
    // ------------------------------------------------------------------
    logic                  b_valid_reg;
    logic [RW-1:0]         b_sat_recip_reg, b_sat_recip_next;
    logic [RW-1:0]         b_hue_recip_reg, b_hue_recip_next;
    logic [15:0]           b_sat_num_reg,   b_sat_num_next;
    logic [13:0]           b_hue_num_reg,   b_hue_num_next;
    logic                  b_neg_reg;
    logic                  b_grey_reg;
    logic [7:0]            b_hi_reg;
    rgbhsv_pkg::sector_t   b_sector_reg;

    always_comb
    begin
        logic [7:0] diff_mag;
        diff_mag = a_diff_reg[8] ? 8'(-a_diff_reg) : a_diff_reg[7:0];
        b_sat_recip_next = recip_lut[a_hi_reg];
        b_hue_recip_next = recip_lut[a_spread_reg];
        // 255 * spread written as a shift and a subtract.
        b_sat_num_next   = {a_spread_reg, 8'd0} - {8'd0, a_spread_reg};
        b_hue_num_next   = 14'(diff_mag) * 14'(rgbhsv_pkg::HUE_SCALE);
    end

    // ------------------------------------------------------------------
    // Stage C: multiply by the reciprocals; the quotient is the top bits.
    // ------------------------------------------------------------------
    logic                  c_valid_reg;
    logic [7:0]            c_sat_q_reg,  c_sat_q_next;
    logic [7:0]            c_hue_q_reg,  c_hue_q_next;
    logic                  c_neg_reg;
    logic                  c_grey_reg;
    logic [7:0]            c_hi_reg;
    rgbhsv_pkg::sector_t   c_sector_reg;

    always_comb
    begin
        logic [RW+15:0] sat_prod;
        logic [RW+13:0] hue_prod;
        sat_prod     = (RW+16)'(b_sat_num_reg) * (RW+16)'(b_sat_recip_reg);
        hue_prod     = (RW+14)'(b_hue_num_reg) * (RW+14)'(b_hue_recip_reg);
        c_sat_q_next = sat_prod[RS+7:RS];
        c_hue_q_next = hue_prod[RS+7:RS];
    end

    // ------------------------------------------------------------------
    // Stage D: sector offset plus signed quotient, modulo 256. A negative
    // red-sector hue wraps into 213..255 by the 8-bit truncation.
    // ------------------------------------------------------------------
    logic                  done_reg;
    rgbhsv_pkg::hsv_t      result_reg, result_next;

    always_comb
    begin
        logic [7:0] ofs;
        logic [7:0] q_signed;
        case (c_sector_reg)
            rgbhsv_pkg::SECTOR_RED:   ofs = rgbhsv_pkg::HUE_OFS_RED;
            rgbhsv_pkg::SECTOR_GREEN: ofs = rgbhsv_pkg::HUE_OFS_GREEN;
            rgbhsv_pkg::SECTOR_BLUE:  ofs = rgbhsv_pkg::HUE_OFS_BLUE;
            default:                  ofs = rgbhsv_pkg::HUE_OFS_RED;
        endcase
        q_signed = c_neg_reg ? 8'(-c_hue_q_reg) : c_hue_q_reg;

        result_next.brightness = c_hi_reg;
        if (c_grey_reg)
        begin
            // Black or grey pixel: no hue and no saturation.
            result_next.hue        = 8'd0;
            result_next.saturation = 8'd0;
        end
        else
        begin
            result_next.hue        = ofs + q_signed;
            result_next.saturation = c_sat_q_reg;
        end
    end

    // Valid bits and the done strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            done_reg    <= c_valid_reg;
        end
    end

    // Payload registers; they move every cycle, so no enable is needed.
    always_ff @(posedge clk)
    begin
        a_hi_reg        <= a_hi_next;
        a_spread_reg    <= a_spread_next;
        a_sector_reg    <= a_sector_next;
        a_diff_reg      <= a_diff_next;

        b_sat_recip_reg <= b_sat_recip_next;
        b_hue_recip_reg <= b_hue_recip_next;
        b_sat_num_reg   <= b_sat_num_next;
        b_hue_num_reg   <= b_hue_num_next;
        b_neg_reg       <= a_diff_reg[8];
        b_grey_reg      <= (a_spread_reg == 8'd0);
        b_hi_reg        <= a_hi_reg;
        b_sector_reg    <= a_sector_reg;

        c_sat_q_reg     <= c_sat_q_next;
        c_hue_q_reg     <= c_hue_q_next;
        c_neg_reg       <= b_neg_reg;
        c_grey_reg      <= b_grey_reg;
        c_hi_reg        <= b_hi_reg;
        c_sector_reg    <= b_sector_reg;

        result_reg      <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted item comes out on done after the A, B, C valid and done registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("item did not reach the output after four cycles");

    // A strobe is only ever driven by an item in the last stage.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(c_valid_reg))
        else $error("done without an item in flight");

    // Zero saturation means a grey pixel, which must carry zero hue.
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturation == 8'd0) |-> (result.hue == 8'd0))
        else $error("grey pixel with nonzero hue");

    // A black pixel has neither hue nor saturation.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.brightness == 8'd0) |->
            (result.hue == 8'd0 && result.saturation == 8'd0))
        else $error("black pixel with nonzero hue or saturation");

endmodule
